// ===== sv/ordered_list_store_core_assert.svh =====
// ----------------------------------------------------------------------------
// ordered list store assertion macros
// Property shorthands on clk with synchronous reset rst
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_STORE_CORE_ASSERT_SVH
`define ORDERED_LIST_STORE_CORE_ASSERT_SVH

// same-cycle implication
`define OLST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OLST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/olst_pkg.sv =====
// ----------------------------------------------------------------------------
// olst_pkg
// Shared sizes, codes and cell control type for the ordered list store
// ----------------------------------------------------------------------------
package olst_pkg;

  // list geometry
  localparam int DEPTH  = 128;
  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // requested actions
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_SEARCH = 2'd3;

  // result status
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // cell operations
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_ROTATE = 2'd1;
  localparam logic [1:0] CELL_INSERT = 2'd2;
  localparam logic [1:0] CELL_DELETE = 2'd3;

  // broadcast control to every cell
  typedef struct packed {
    logic [1:0]              op;
    logic [IDX_W-1:0]        sel;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

  // low byte of a count or position
  function automatic logic [POS_W-1:0] to_byte(logic [WIDE_W-1:0] v);
    return v[POS_W-1:0];
  endfunction

endpackage

// ===== sv/olst_cell.sv =====
// ----------------------------------------------------------------------------
// olst_cell
// One list slot: holds an entry and loads from a neighbor or the broadcast value
// ----------------------------------------------------------------------------
module olst_cell (
  input  logic                          clk,
  input  olst_pkg::cell_ctl_t           ctl,
  input  logic [olst_pkg::IDX_W-1:0]    idx,
  input  logic signed [olst_pkg::DATA_W-1:0] left_data,
  input  logic signed [olst_pkg::DATA_W-1:0] right_data,
  output logic signed [olst_pkg::DATA_W-1:0] data
);
  import olst_pkg::*;

  // slot update
  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_ROTATE: begin
        data <= right_data;
      end
      CELL_INSERT: begin
        if (idx > ctl.sel) begin
          data <= left_data;
        end else if (idx == ctl.sel) begin
          data <= ctl.value;
        end
      end
      CELL_DELETE: begin
        if (idx >= ctl.sel) begin
          data <= right_data;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

// ===== sv/olst_chain.sv =====
// ----------------------------------------------------------------------------
// olst_chain
// Ring of list cells; cell zero is the head seen by the controller
// ----------------------------------------------------------------------------
module olst_chain (
  input  logic                               clk,
  input  olst_pkg::cell_ctl_t                ctl,
  output logic signed [olst_pkg::DATA_W-1:0] head
);
  import olst_pkg::*;

  logic signed [DATA_W-1:0] slot [DEPTH];

  // cells wired as a ring, each to its two neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    olst_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (IDX_W'(i)),
      .left_data  (slot[(i + DEPTH - 1) % DEPTH]),
      .right_data (slot[(i + 1) % DEPTH]),
      .data       (slot[i])
    );
  end

  assign head = slot[0];

endmodule

// ===== sv/ordered_list_store_core.sv =====
// ----------------------------------------------------------------------------
// ordered_list_store_core
// Ordered list of signed entries with append, insert, delete and search
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | action, position, value
// out     | output    | out_valid / out_ready| status, removed_value,
//         |           |                      | found_position, entry_count
//
// Append, insert and every refused action give a result in the cycle after
// the transfer. An in-range delete and every search rotate the cell ring once
// past the head cell in the scan state, then load the result in the done state.
// One item is worked on at a time; a new item is taken when the block is idle
// and the output register is empty or being drained.
// Reset clears the count and the handshake state; the cells are not cleared.
// A stalled result holds the block in its finishing step until it drains.
// ----------------------------------------------------------------------------
`include "ordered_list_store_core_assert.svh"

module ordered_list_store_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         action,
  input  logic [olst_pkg::POS_W-1:0]         position,
  input  logic signed [olst_pkg::DATA_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic signed [olst_pkg::DATA_W-1:0] removed_value,
  output logic [olst_pkg::POS_W-1:0]         found_position,
  output logic [olst_pkg::POS_W-1:0]         entry_count
);
  import olst_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]               state;
  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         step;
  logic [1:0]               act;
  logic [IDX_W-1:0]         pos_m1;
  logic signed [DATA_W-1:0] val;
  logic                     hit;
  logic [IDX_W-1:0]         hit_pos;
  logic signed [DATA_W-1:0] removed;

  logic                     full;
  logic                     pos_ok;
  logic [WIDE_W-1:0]        pos_w;
  logic [IDX_W-1:0]         pos_m1_in;
  logic                     slot_free;
  logic                     in_fire;
  logic                     out_load;
  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] head;

  // request checks
  always_comb begin
    full      = (count == CNT_W'(DEPTH));
    pos_w     = WIDE_W'(position);
    pos_ok    = (position != '0) && (pos_w <= WIDE_W'(count));
    pos_m1_in = IDX_W'(pos_w - WIDE_W'(1));
    slot_free = !out_valid || out_ready;
    in_ready  = (state == S_IDLE) && slot_free;
    in_fire   = in_valid && in_ready;
    // a result is loaded into the output register on this edge
    out_load  = ((state == S_DONE) && slot_free) ||
                ((state == S_IDLE) && in_fire &&
                 ((action inside {ACT_APPEND, ACT_INSERT}) ||
                  (action == ACT_DELETE && !pos_ok)));
  end

  // broadcast control to the cell ring
  always_comb begin
    ctl.op    = CELL_HOLD;
    ctl.sel   = pos_m1_in;
    ctl.value = value;
    case (state)
      S_IDLE: begin
        if (in_fire && !full) begin
          if (action == ACT_APPEND) begin
            ctl.op  = CELL_INSERT;
            ctl.sel = IDX_W'(count);
          end else if (action == ACT_INSERT && pos_ok) begin
            ctl.op = CELL_INSERT;
          end
        end
      end
      S_SCAN: begin
        ctl.op = CELL_ROTATE;
      end
      S_DONE: begin
        if (slot_free && act == ACT_DELETE) begin
          ctl.op  = CELL_DELETE;
          ctl.sel = pos_m1;
        end
      end
      default: begin
        ctl.op = CELL_HOLD;
      end
    endcase
  end

  olst_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  // control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            act            <= action;
            pos_m1         <= pos_m1_in;
            val            <= value;
            step           <= '0;
            hit            <= 1'b0;
            hit_pos        <= '0;
            removed        <= '0;
            removed_value  <= '0;
            found_position <= '0;
            case (action)
              ACT_APPEND: begin
                out_valid <= 1'b1;
                if (full) begin
                  status      <= ST_FULL;
                  entry_count <= to_byte(WIDE_W'(count));
                end else begin
                  status      <= ST_DONE;
                  count       <= count + 1'b1;
                  entry_count <= to_byte(WIDE_W'(count) + WIDE_W'(1));
                end
              end
              ACT_INSERT: begin
                out_valid <= 1'b1;
                if (full) begin
                  status      <= ST_FULL;
                  entry_count <= to_byte(WIDE_W'(count));
                end else if (!pos_ok) begin
                  status      <= ST_RANGE;
                  entry_count <= to_byte(WIDE_W'(count));
                end else begin
                  status      <= ST_DONE;
                  count       <= count + 1'b1;
                  entry_count <= to_byte(WIDE_W'(count) + WIDE_W'(1));
                end
              end
              ACT_DELETE: begin
                if (!pos_ok) begin
                  out_valid   <= 1'b1;
                  status      <= ST_RANGE;
                  entry_count <= to_byte(WIDE_W'(count));
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          // head cell sees original entry step on this cycle
          if (act == ACT_SEARCH) begin
            if (!hit && (CNT_W'(step) < count) && (head == val)) begin
              hit     <= 1'b1;
              hit_pos <= step;
            end
          end else if (step == pos_m1) begin
            removed <= head;
          end
          step <= step + 1'b1;
          if (step == IDX_W'(DEPTH - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (act == ACT_DELETE) begin
              status         <= ST_DONE;
              removed_value  <= removed;
              found_position <= '0;
              count          <= count - 1'b1;
              entry_count    <= to_byte(WIDE_W'(count) - WIDE_W'(1));
            end else begin
              status         <= hit ? ST_DONE : ST_NOTFOUND;
              removed_value  <= '0;
              found_position <= hit ? to_byte(WIDE_W'(hit_pos) + WIDE_W'(1)) : '0;
              entry_count    <= to_byte(WIDE_W'(count));
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `OLST_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "count above depth")
  `OLST_ASSERT_NEXT(a_append_grows, in_fire && action == ACT_APPEND && !full,
    count == $past(count) + 1'b1, "append did not grow the list")
  `OLST_ASSERT_NEXT(a_scan_ends, state == S_SCAN && step == IDX_W'(DEPTH - 1),
    state == S_DONE, "ring scan did not end after one turn")
  `OLST_ASSERT_NEXT(a_delete_shrinks, state == S_DONE && slot_free && act == ACT_DELETE,
    count == $past(count) - 1'b1 && out_valid, "delete did not shrink the list")

endmodule
